@@ hw/rtl/mhpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpt_pkg
// Shared types, widths and constants of the moving-head pan/tilt aim block.
// ----------------------------------------------------------------------------
package mhpt_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_AIMED = 2'd0,
    ST_SKIP  = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [2:0] REG_SPAN_X = 3'd0;
  localparam logic [2:0] REG_SPAN_Y = 3'd1;
  localparam logic [2:0] REG_SPAN_Z = 3'd2;
  localparam logic [2:0] REG_BASE_X = 3'd3;
  localparam logic [2:0] REG_BASE_Y = 3'd4;
  localparam logic [2:0] REG_BASE_Z = 3'd5;

  // datapath widths
  localparam int VW  = 31;  // scaled vector component, signed, |v| < 2^30
  localparam int CW  = 34;  // CORDIC x/y
  localparam int ZW  = 26;  // CORDIC angle, 2^-15 degree
  localparam int NW  = 62;  // square-root radicand
  localparam int HW  = 31;  // square-root result
  localparam int ISQ_STAGES = 31;

  localparam logic signed [ZW-1:0] HALF_TURN_Z = 26'sd5898240;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 26'sd128;
  localparam logic signed [17:0]   PAN_LIMIT   = 18'sd11520;
  localparam logic signed [17:0]   TILT_LIMIT  = 18'sd23040;

  typedef struct packed {
    status_t               status;
    logic [23:0]           color;
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic signed [VW-1:0]  vz;
  } aim_sb_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] color;
    logic        vx_zero;
    logic        vy_neg;
    logic        vy_zero;
  } pan_sb_t;

  // atan(2^-i) in 2^-15 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_z(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:  val = 26'sd1474560;
      5'd1:  val = 26'sd870484;
      5'd2:  val = 26'sd459940;
      5'd3:  val = 26'sd233473;
      5'd4:  val = 26'sd117189;
      5'd5:  val = 26'sd58652;
      5'd6:  val = 26'sd29333;
      5'd7:  val = 26'sd14667;
      5'd8:  val = 26'sd7334;
      5'd9:  val = 26'sd3667;
      5'd10: val = 26'sd1833;
      5'd11: val = 26'sd917;
      5'd12: val = 26'sd458;
      5'd13: val = 26'sd229;
      5'd14: val = 26'sd115;
      5'd15: val = 26'sd57;
      5'd16: val = 26'sd29;
      5'd17: val = 26'sd14;
      5'd18: val = 26'sd7;
      5'd19: val = 26'sd4;
      5'd20: val = 26'sd2;
      5'd21: val = 26'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/moving_head_pan_tilt_aim.sv @@
// ----------------------------------------------------------------------------
// moving_head_pan_tilt_aim
// Maps two position ratios into a 3-D box and aims a moving head at the point.
// ----------------------------------------------------------------------------
// One request is taken every cycle: busy stays low. Each result appears on
// out_valid after seven stages of scaling and squaring, a 31-stage square
// root, then the pan and tilt CORDIC pipelines running side by side and one
// output register.
module moving_head_pan_tilt_aim import mhpt_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_ratio_x,
  input  logic signed [15:0] in_ratio_y,
  input  logic [23:0]        in_light_color,
  output logic               out_valid,
  output logic signed [14:0] out_pan_angle,
  output logic signed [15:0] out_tilt_angle,
  output logic [23:0]        out_color,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = 39 + CORDIC_STEPS;

  // ---------------- configuration ----------------
  logic signed [19:0] span_x_r, span_y_r, span_z_r;
  logic signed [20:0] base_x_r, base_y_r, base_z_r;
  logic [2:0]         reg_idx;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_x_r <= '0;
      span_y_r <= '0;
      span_z_r <= '0;
      base_x_r <= '0;
      base_y_r <= '0;
      base_z_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SPAN_X: span_x_r <= pwdata[19:0];
        REG_SPAN_Y: span_y_r <= pwdata[19:0];
        REG_SPAN_Z: span_z_r <= pwdata[19:0];
        REG_BASE_X: base_x_r <= pwdata[20:0];
        REG_BASE_Y: base_y_r <= pwdata[20:0];
        REG_BASE_Z: base_z_r <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPAN_X: prdata = 32'(span_x_r);
      REG_SPAN_Y: prdata = 32'(span_y_r);
      REG_SPAN_Z: prdata = 32'(span_z_r);
      REG_BASE_X: prdata = 32'(base_x_r);
      REG_BASE_Y: prdata = 32'(base_y_r);
      REG_BASE_Z: prdata = 32'(base_z_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- front pipeline ----------------
  logic in_accept;
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  // stage 1: span * ratio
  logic signed [35:0] p_x_r, p_y_r, p_z_r;
  logic               s1_skip_r;
  logic [23:0]        s1_color_r;

  always_ff @(posedge clk) begin
    p_x_r      <= span_x_r * in_ratio_x;
    p_y_r      <= span_y_r * in_ratio_y;
    p_z_r      <= span_z_r * in_ratio_y;
    s1_skip_r  <= in_ratio_x[15] | in_ratio_y[15];
    s1_color_r <= in_light_color;
  end

  // stage 2: add box base, exact Q14
  logic signed [36:0] v_x_r, v_y_r, v_z_r;
  logic               s2_skip_r;
  logic [23:0]        s2_color_r;

  always_ff @(posedge clk) begin
    v_x_r      <= 37'(p_x_r) + (37'(base_x_r) <<< 14);
    v_y_r      <= 37'(p_y_r) + (37'(base_y_r) <<< 14);
    v_z_r      <= 37'(p_z_r) + (37'(base_z_r) <<< 14);
    s2_skip_r  <= s1_skip_r;
    s2_color_r <= s1_color_r;
  end

  // stage 3: magnitudes, status
  logic [35:0] m_x_r, m_y_r, m_z_r;
  logic        n_x_r, n_y_r, n_z_r;
  status_t     s3_st_r, s3_st_nxt;
  logic [23:0] s3_color_r;

  always_comb begin
    if (s2_skip_r)                                 s3_st_nxt = ST_SKIP;
    else if (v_x_r == '0 && v_y_r == '0 && v_z_r == '0) s3_st_nxt = ST_ZERO;
    else                                           s3_st_nxt = ST_AIMED;
  end

  always_ff @(posedge clk) begin
    m_x_r      <= v_x_r[36] ? 36'(-v_x_r) : 36'(v_x_r);
    m_y_r      <= v_y_r[36] ? 36'(-v_y_r) : 36'(v_y_r);
    m_z_r      <= v_z_r[36] ? 36'(-v_z_r) : 36'(v_z_r);
    n_x_r      <= v_x_r[36];
    n_y_r      <= v_y_r[36];
    n_z_r      <= v_z_r[36];
    s3_st_r    <= s3_st_nxt;
    s3_color_r <= s2_color_r;
  end

  // stage 4: common shift so every magnitude is below 2^30
  logic [35:0] m_max;
  logic [2:0]  sh_nxt, sh_r;
  logic [35:0] m4_x_r, m4_y_r, m4_z_r;
  logic        n4_x_r, n4_y_r, n4_z_r;
  status_t     s4_st_r;
  logic [23:0] s4_color_r;

  always_comb begin
    m_max = m_x_r;
    if (m_y_r > m_max) m_max = m_y_r;
    if (m_z_r > m_max) m_max = m_z_r;
    sh_nxt = 3'd6;
    for (int j = 5; j >= 0; j--) begin
      if ((m_max >> j) < (36'd1 << 30)) sh_nxt = 3'(j);
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    m4_x_r     <= m_x_r;
    m4_y_r     <= m_y_r;
    m4_z_r     <= m_z_r;
    n4_x_r     <= n_x_r;
    n4_y_r     <= n_y_r;
    n4_z_r     <= n_z_r;
    s4_st_r    <= s3_st_r;
    s4_color_r <= s3_color_r;
  end

  // stage 5: rescale, truncation toward zero
  logic [29:0]          a_x, a_y, a_z;
  logic [29:0]          a_x_r, a_y_r;
  logic signed [VW-1:0] s_x_r, s_y_r, s_z_r;
  status_t              s5_st_r;
  logic [23:0]          s5_color_r;

  always_comb begin
    a_x = 30'(m4_x_r >> sh_r);
    a_y = 30'(m4_y_r >> sh_r);
    a_z = 30'(m4_z_r >> sh_r);
  end

  always_ff @(posedge clk) begin
    a_x_r      <= a_x;
    a_y_r      <= a_y;
    s_x_r      <= n4_x_r ? -VW'(a_x) : VW'(a_x);
    s_y_r      <= n4_y_r ? -VW'(a_y) : VW'(a_y);
    s_z_r      <= n4_z_r ? -VW'(a_z) : VW'(a_z);
    s5_st_r    <= s4_st_r;
    s5_color_r <= s4_color_r;
  end

  // stage 6: squares
  logic [59:0] sq_x_r, sq_y_r;
  aim_sb_t     s6_sb_r;

  always_ff @(posedge clk) begin
    sq_x_r         <= a_x_r * a_x_r;
    sq_y_r         <= a_y_r * a_y_r;
    s6_sb_r.status <= s5_st_r;
    s6_sb_r.color  <= s5_color_r;
    s6_sb_r.vx     <= s_x_r;
    s6_sb_r.vy     <= s_y_r;
    s6_sb_r.vz     <= s_z_r;
  end

  // stage 7: radicand
  logic [NW-1:0] rad_r;
  aim_sb_t       s7_sb_r;

  always_ff @(posedge clk) begin
    rad_r   <= NW'(sq_x_r) + NW'(sq_y_r);
    s7_sb_r <= s6_sb_r;
  end

  // ---------------- square root ----------------
  logic                  q_v;
  logic [HW-1:0]         q_h;
  logic [$bits(aim_sb_t)-1:0] q_sb_bits;
  aim_sb_t               q_sb;

  mhpt_isqrt #(.SB_W($bits(aim_sb_t))) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s7_v_r),
    .in_n     (rad_r),
    .in_sb    (s7_sb_r),
    .out_valid(q_v),
    .out_root (q_h),
    .out_sb   (q_sb_bits)
  );

  assign q_sb = aim_sb_t'(q_sb_bits);

  // ---------------- CORDIC inputs ----------------
  logic signed [CW-1:0] ex, ey, ez, pan_x, pan_y, tilt_x, tilt_y;
  logic                 vz_pos;
  pan_sb_t              p_sb_in;

  always_comb begin
    ex     = CW'(q_sb.vx);
    ey     = CW'(q_sb.vy);
    ez     = CW'(q_sb.vz);
    pan_x  = ex[CW-1] ? -ex : ex;
    pan_y  = (!ex[CW-1] && ex != '0) ? -ey : ey;
    vz_pos = !ez[CW-1] && ez != '0;
    tilt_x = vz_pos ? ez : -ez;
    tilt_y = CW'({1'b0, q_h});
    p_sb_in.status  = q_sb.status;
    p_sb_in.color   = q_sb.color;
    p_sb_in.vx_zero = (q_sb.vx == '0);
    p_sb_in.vy_neg  = q_sb.vy[VW-1];
    p_sb_in.vy_zero = (q_sb.vy == '0);
  end

  logic                 pc_v, tc_v;
  logic signed [ZW-1:0] pan_z, tilt_z;
  logic [$bits(pan_sb_t)-1:0] pc_sb_bits;
  logic                 tc_vz_pos;
  pan_sb_t              pc_sb;

  mhpt_cordic #(.STEPS(CORDIC_STEPS), .SB_W($bits(pan_sb_t))) u_pan_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_v),
    .in_x     (pan_x),
    .in_y     (pan_y),
    .in_sb    (p_sb_in),
    .out_valid(pc_v),
    .out_z    (pan_z),
    .out_sb   (pc_sb_bits)
  );

  mhpt_cordic #(.STEPS(CORDIC_STEPS), .SB_W(1)) u_tilt_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_v),
    .in_x     (tilt_x),
    .in_y     (tilt_y),
    .in_sb    (vz_pos),
    .out_valid(tc_v),
    .out_z    (tilt_z),
    .out_sb   (tc_vz_pos)
  );

  assign pc_sb = pan_sb_t'(pc_sb_bits);

  // ---------------- final rounding and clamp ----------------
  logic signed [ZW-1:0] pan_rnd, tilt_a, tilt_rnd;
  logic signed [17:0]   pan_u, tilt_u, pan_c, tilt_c;
  logic signed [14:0]   pan_nxt;
  logic signed [15:0]   tilt_nxt;
  logic [23:0]          color_nxt;

  logic                 out_valid_r;
  logic signed [14:0]   out_pan_r;
  logic signed [15:0]   out_tilt_r;
  logic [23:0]          out_color_r;
  status_t              out_status_r;

  always_comb begin
    pan_rnd  = (pan_z + ROUND_HALF) >>> 8;
    pan_u    = pan_rnd[17:0];
    tilt_a   = tc_vz_pos ? (HALF_TURN_Z - tilt_z) : tilt_z;
    tilt_rnd = (tilt_a + ROUND_HALF) >>> 8;
    tilt_u   = -tilt_rnd[17:0];

    if (pc_sb.vx_zero) begin
      if (pc_sb.vy_zero)     pan_c = '0;
      else if (pc_sb.vy_neg) pan_c = PAN_LIMIT;
      else                   pan_c = -PAN_LIMIT;
    end else if (pan_u > PAN_LIMIT) begin
      pan_c = PAN_LIMIT;
    end else if (pan_u < -PAN_LIMIT) begin
      pan_c = -PAN_LIMIT;
    end else begin
      pan_c = pan_u;
    end

    if (tilt_u > 18'sd0)              tilt_c = '0;
    else if (tilt_u < -TILT_LIMIT)    tilt_c = -TILT_LIMIT;
    else                              tilt_c = tilt_u;

    if (pc_sb.status == ST_AIMED) begin
      pan_nxt  = pan_c[14:0];
      tilt_nxt = tilt_c[15:0];
    end else begin
      pan_nxt  = '0;
      tilt_nxt = '0;
    end
    color_nxt = (pc_sb.status == ST_SKIP) ? 24'd0 : pc_sb.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= pc_v & tc_v;
  end

  always_ff @(posedge clk) begin
    out_pan_r    <= pan_nxt;
    out_tilt_r   <= tilt_nxt;
    out_color_r  <= color_nxt;
    out_status_r <= pc_sb.status;
  end

  assign out_valid      = out_valid_r;
  assign out_pan_angle  = out_pan_r;
  assign out_tilt_angle = out_tilt_r;
  assign out_color      = out_color_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching start beat");

  a_skip_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SKIP |->
      out_color == 24'd0 && out_pan_angle == 15'sd0 && out_tilt_angle == 16'sd0)
    else $error("skipped beat not blanked");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tilt_angle <= 16'sd0 && out_tilt_angle >= -16'sd23040)
    else $error("tilt out of range");
`endif

endmodule

@@ hw/rtl/mhpt_isqrt.sv @@
// ----------------------------------------------------------------------------
// mhpt_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module mhpt_isqrt import mhpt_pkg::*; #(
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_n,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [HW-1:0]   out_root,
  output logic [SB_W-1:0] out_sb
);

  logic            v_r  [ISQ_STAGES];
  logic [NW-1:0]   n_r  [ISQ_STAGES];
  logic [NW-1:0]   r_r  [ISQ_STAGES];
  logic [SB_W-1:0] sb_r [ISQ_STAGES];

  for (genvar i = 0; i < ISQ_STAGES; i++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (ISQ_STAGES - 1 - i));
    logic            vi;
    logic [NW-1:0]   ni, ri, sum, n_nxt, r_nxt;
    logic [SB_W-1:0] sbi;

    if (i == 0) begin : g_first
      assign vi  = in_valid;
      assign ni  = in_n;
      assign ri  = '0;
      assign sbi = in_sb;
    end else begin : g_next
      assign vi  = v_r[i-1];
      assign ni  = n_r[i-1];
      assign ri  = r_r[i-1];
      assign sbi = sb_r[i-1];
    end

    always_comb begin
      sum = ri + BIT;
      if (ni >= sum) begin
        n_nxt = ni - sum;
        r_nxt = (ri >> 1) + BIT;
      end else begin
        n_nxt = ni;
        r_nxt = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= vi;
    end

    always_ff @(posedge clk) begin
      n_r[i]  <= n_nxt;
      r_r[i]  <= r_nxt;
      sb_r[i] <= sbi;
    end
  end

  assign out_valid = v_r[ISQ_STAGES-1];
  assign out_root  = r_r[ISQ_STAGES-1][HW-1:0];
  assign out_sb    = sb_r[ISQ_STAGES-1];

endmodule

@@ hw/rtl/mhpt_cordic.sv @@
// ----------------------------------------------------------------------------
// mhpt_cordic
// Pipelined vectoring CORDIC, one iteration per stage; atan2(y, x), x >= 0.
// ----------------------------------------------------------------------------
module mhpt_cordic import mhpt_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output logic [SB_W-1:0]      out_sb
);

  logic                 v_r  [STEPS];
  logic signed [CW-1:0] x_r  [STEPS];
  logic signed [CW-1:0] y_r  [STEPS];
  logic signed [ZW-1:0] z_r  [STEPS];
  logic [SB_W-1:0]      sb_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                 vi;
    logic signed [CW-1:0] xi, yi, dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] zi, z_nxt;
    logic [SB_W-1:0]      sbi;

    if (i == 0) begin : g_first
      assign vi  = in_valid;
      assign xi  = in_x;
      assign yi  = in_y;
      assign zi  = '0;
      assign sbi = in_sb;
    end else begin : g_next
      assign vi  = v_r[i-1];
      assign xi  = x_r[i-1];
      assign yi  = y_r[i-1];
      assign zi  = z_r[i-1];
      assign sbi = sb_r[i-1];
    end

    always_comb begin
      dx = yi >>> i;
      dy = xi >>> i;
      if (!yi[CW-1]) begin
        x_nxt = xi + dx;
        y_nxt = yi - dy;
        z_nxt = zi + atan_z(5'(i));
      end else begin
        x_nxt = xi - dx;
        y_nxt = yi + dy;
        z_nxt = zi - atan_z(5'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else        v_r[i] <= vi;
    end

    always_ff @(posedge clk) begin
      x_r[i]  <= x_nxt;
      y_r[i]  <= y_nxt;
      z_r[i]  <= z_nxt;
      sb_r[i] <= sbi;
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_sb    = sb_r[STEPS-1];

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the moving-head pan/tilt aim block against a behavioral predictor.
// Box registers are set over APB between phases. Aim requests then go in
// bursts with random gaps, and every result beat is compared in order with
// the predicted pan, tilt, color and status.
// ----------------------------------------------------------------------------
module tb_top;
  import mhpt_pkg::*;

  localparam int STEPS      = 16;
  localparam int LATENCY    = 39 + STEPS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [14:0] pan;
    logic signed [15:0] tilt;
    logic [23:0]        color;
    status_t            status;
  } aim_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_ratio_x = '0;
  logic signed [15:0] in_ratio_y = '0;
  logic [23:0]        in_light_color = '0;
  logic               out_valid;
  logic signed [14:0] out_pan_angle;
  logic signed [15:0] out_tilt_angle;
  logic [23:0]        out_color;
  logic [1:0]         out_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  moving_head_pan_tilt_aim #(.CORDIC_STEPS(STEPS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // box registers as the predictor sees them
  longint span_x, span_y, span_z, base_x, base_y, base_z;
  aim_result_t aims_pending[$];
  int  n_errors = 0;
  longint cycles = 0;
  int  burst_left = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(input int i);
    longint t[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
                      14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
                      7, 4, 2, 1, 0, 0};
    return t[i];
  endfunction

  // vectoring rotation, x >= 0, angle in 2^-15 degree
  function automatic longint vector_angle(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint shrink(input longint v, input int s);
    longint m;
    m = (v < 0 ? -v : v) >> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic aim_result_t predict_aim(input logic signed [15:0] rx,
                                              input logic signed [15:0] ry,
                                              input logic [23:0] col);
    aim_result_t r;
    longint vx, vy, vz, m, pan, tilt, a, h;
    int s;
    r = '0;
    r.color = col;
    r.status = ST_AIMED;
    pan = 0;
    tilt = 0;
    if (rx < 0 || ry < 0) begin
      r.status = ST_SKIP;
      r.color = '0;
    end else begin
      vx = span_x * rx + base_x * 16384;
      vy = span_y * ry + base_y * 16384;
      vz = span_z * ry + base_z * 16384;
      if (vx == 0 && vy == 0 && vz == 0) begin
        r.status = ST_ZERO;
      end else begin
        m = vx < 0 ? -vx : vx;
        if ((vy < 0 ? -vy : vy) > m) m = vy < 0 ? -vy : vy;
        if ((vz < 0 ? -vz : vz) > m) m = vz < 0 ? -vz : vz;
        s = 0;
        while ((m >> s) >= (64'sd1 <<< 30)) s++;
        vx = shrink(vx, s);
        vy = shrink(vy, s);
        vz = shrink(vz, s);
        if (vx == 0) pan = vy < 0 ? 11520 : (vy > 0 ? -11520 : 0);
        else pan = floor_shr(vector_angle(vx > 0 ? vx : -vx, vx > 0 ? -vy : vy) + 128, 8);
        if (pan > 11520) pan = 11520;
        if (pan < -11520) pan = -11520;
        h = int_sqrt(vx * vx + vy * vy);
        if (-vz >= 0) a = vector_angle(-vz, h);
        else a = 5898240 - vector_angle(vz, h);
        tilt = -floor_shr(a + 128, 8);
        if (tilt > 0) tilt = 0;
        if (tilt < -23040) tilt = -23040;
      end
    end
    r.pan = pan[14:0];
    r.tilt = tilt[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result checker: the block cannot be stalled, so every strobe is a beat
  always @(posedge clk) begin
    aim_result_t want;
    if (rst_n && out_valid) begin
      if (aims_pending.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = aims_pending.pop_front();
        if (out_pan_angle !== want.pan) report_mismatch("pan", out_pan_angle, want.pan);
        if (out_tilt_angle !== want.tilt) report_mismatch("tilt", out_tilt_angle, want.tilt);
        if (out_color !== want.color) report_mismatch("color", out_color, want.color);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value[31:0];
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle between transfers
    @(posedge clk);
    case (idx)
      REG_SPAN_X: span_x = value;
      REG_SPAN_Y: span_y = value;
      REG_SPAN_Z: span_z = value;
      REG_BASE_X: base_x = value;
      REG_BASE_Y: base_y = value;
      default:    base_z = value;
    endcase
  endtask

  task automatic set_box(input longint sx, sy, sz, bx, by, bz);
    write_reg(REG_SPAN_X, sx);
    write_reg(REG_SPAN_Y, sy);
    write_reg(REG_SPAN_Z, sz);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_BASE_Z, bz);
  endtask

  // holds start high across bursts, drops it for random gaps
  task automatic send_aim(input logic signed [15:0] rx, input logic signed [15:0] ry,
                          input logic [23:0] col);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    in_ratio_x     <= rx;
    in_ratio_y     <= ry;
    in_light_color <= col;
    do @(posedge clk); while (busy);
    aims_pending.push_back(predict_aim(rx, ry, col));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (aims_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_ratio;
    case ($urandom_range(0, 5))
      0:       return 16'sd0;
      1:       return 16'sd16384;
      2:       return 16'sd32767;
      3:       return 16'($urandom_range(0, 32767));
      4:       return 16'(-$urandom_range(1, 32768));
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic longint rand_span;
    case ($urandom_range(0, 4))
      0:       return 524287;
      1:       return -524288;
      2:       return 0;
      default: return $signed($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  function automatic longint rand_base;
    case ($urandom_range(0, 4))
      0:       return 1048575;
      1:       return -1048576;
      2:       return 0;
      default: return $signed($urandom_range(0, 2097151)) - 1048576;
    endcase
  endfunction

  task automatic test_directed;
    set_box(4000, 3000, -2000, -2000, 500, 1000);
    send_aim(16'sd0, 16'sd0, 24'hFFFFFF);
    send_aim(16'sd16384, 16'sd16384, 24'h000000);
    send_aim(16'sd32767, 16'sd32767, 24'hA5A55A);
    send_aim(-16'sd1, 16'sd100, 24'h123456);
    send_aim(16'sd100, -16'sd32768, 24'h654321);
    send_aim(-16'sd32768, -16'sd1, 24'hFFFFFF);
    send_aim(16'sd8192, 16'sd8192, 24'h0F0F0F);
    drain();
    // zero vector and vertical aim: X collapses to zero
    set_box(0, 0, 0, 0, 0, 0);
    send_aim(16'sd5000, 16'sd5000, 24'h808080);
    drain();
    set_box(0, 1000, 1000, 0, -500, 0);
    send_aim(16'sd1000, 16'sd0, 24'h010203);
    send_aim(16'sd1000, 16'sd16384, 24'h040506);
    send_aim(16'sd1000, 16'sd8192, 24'h070809);
    drain();
    set_box(0, 0, 1000, 0, 0, -1000);
    send_aim(16'sd3, 16'sd0, 24'h111111);
    send_aim(16'sd3, 16'sd32767, 24'h222222);
    drain();
    // extremes of every register
    set_box(524287, -524288, 524287, 1048575, -1048576, 1048575);
    send_aim(16'sd32767, 16'sd32767, 24'hFFFFFF);
    send_aim(16'sd0, 16'sd0, 24'h800001);
    drain();
    set_box(-524288, 524287, -524288, -1048576, 1048575, -1048576);
    send_aim(16'sd32767, 16'sd32767, 24'h7FFFFE);
    send_aim(16'sd0, 16'sd32767, 24'h000001);
    drain();
  endtask

  task automatic test_random(input int n_phases, input int per_phase);
    for (int p = 0; p < n_phases; p++) begin
      set_box(rand_span(), rand_span(), rand_span(), rand_base(), rand_base(), rand_base());
      for (int i = 0; i < per_phase; i++)
        send_aim(rand_ratio(), rand_ratio(), 24'($urandom_range(0, 24'hFFFFFF)));
      drain();
    end
  endtask

  initial begin
    span_x = 0; span_y = 0; span_z = 0;
    base_x = 0; base_y = 0; base_z = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(15, 110);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mhpt_pkg.sv
hw/rtl/mhpt_isqrt.sv
hw/rtl/mhpt_cordic.sv
hw/rtl/moving_head_pan_tilt_aim.sv
verif/tb_top.sv
